FILE: rtl/srm_pkg.sv
package srm_pkg;

  localparam int unsigned IVAL_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned PANEL_W  = 9;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [RATE_W-1:0] RATE_NUM = 16'd60000;

  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_HIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 1'b1;

  localparam logic [CFG_W-1:0] DOUBLE_HIT_RST = 16'd30;
  localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd2000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_PUSH,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_RATE_GO,
    S_RATE_WAIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic read;
    logic push;
    logic start_mean;
    logic start_rate;
    logic rate_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic push_req;
    logic div_done;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/srm_if.sv
interface srm_in_if;
  logic                          valid;
  logic                          ready;
  logic [srm_pkg::TIME_W-1:0]    now_ms;
  logic [srm_pkg::PANEL_W-1:0]   panels;

  modport source (output valid, output now_ms, output panels, input ready);
  modport sink   (input valid, input now_ms, input panels, output ready);
endinterface

interface srm_out_if;
  logic                          valid;
  logic                          ready;
  logic [srm_pkg::RATE_W-1:0]    rate_per_minute;
  logic                          press_counted;
  logic [srm_pkg::FILL_W-1:0]    window_fill;

  modport source (output valid, output rate_per_minute, output press_counted,
                  output window_fill, input ready);
  modport sink   (input valid, input rate_per_minute, input press_counted,
                  input window_fill, output ready);
endinterface

FILE: rtl/step_rate_meter_unit.sv
// channel | dir | payload                                        | transfer
// in_ch   | in  | now_ms[31:0], panels[8:0]                      | valid & ready
// out_ch  | out | rate_per_minute[15:0], press_counted, fill[4:0] | valid & ready
// cfg     | in  | cfg_index (0 double_hit_ms, 1 timeout_ms), data | cfg_we
//
// A sample without a window update goes straight from evaluation to the result
// stage; one that updates the window writes it, then the shared radix-2 divider
// (dividend SUM_W = 16 + clog2(WIN_DEPTH+1)) forms the mean and then the rate.
// One sample is in flight at a time; the next is taken while a result waits.
// Synchronous active-low reset; a stalled output holds its result.
module step_rate_meter_unit #(
  parameter int unsigned WIN_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  srm_in_if.sink                        in_ch,
  srm_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [srm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srm_pkg::CFG_W-1:0]     cfg_data
);

  srm_pkg::cmd_t  cmd;
  srm_pkg::stat_t st;

  srm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  srm_dp #(
    .WIN_DEPTH (WIN_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_now_ms           (in_ch.now_ms),
    .in_panels           (in_ch.panels),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_rate_per_minute (out_ch.rate_per_minute),
    .out_press_counted   (out_ch.press_counted),
    .out_window_fill     (out_ch.window_fill)
  );

`ifndef NO_ASSERTIONS
  a_no_take_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !st.div_busy)
    else $error("input transfer while divider busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (WIN_DEPTH > 31 ||
                      out_ch.window_fill <= srm_pkg::FILL_W'(WIN_DEPTH)))
    else $error("window fill above window size");

  a_empty_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.window_fill == '0 && WIN_DEPTH < 32)
      |-> out_ch.rate_per_minute == '0)
    else $error("nonzero rate with empty window");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten before transfer");
`endif

endmodule

FILE: rtl/srm_div.sv
module srm_div #(
  parameter int unsigned DND_W = 21,
  parameter int unsigned DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DND_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DND_W-1:0] quotient,
  output logic             busy,
  output logic             done
);

  localparam int unsigned CNT_W = $clog2(DND_W + 1);

  logic [DND_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  always_comb begin
    trial = {rem_r, quo_r[DND_W-1]};
    diff  = trial - {1'b0, dvs_r};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[DVS_W-1:0];
      quo_nxt = {quo_r[DND_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DVS_W-1:0];
      quo_nxt = {quo_r[DND_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign busy     = busy_r;
  assign done     = done_r;

endmodule

FILE: rtl/srm_ctrl.sv
module srm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  srm_pkg::stat_t st,
  output srm_pkg::cmd_t  cmd
);

  srm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      srm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = srm_pkg::S_EVAL;
        end
      end
      srm_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        if (st.push_req) begin
          state_nxt = srm_pkg::S_READ;
        end else begin
          state_nxt = srm_pkg::S_RATE_WAIT;
        end
      end
      srm_pkg::S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = srm_pkg::S_PUSH;
      end
      srm_pkg::S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = srm_pkg::S_MEAN_GO;
      end
      srm_pkg::S_MEAN_GO: begin
        cmd.start_mean = 1'b1;
        state_nxt      = srm_pkg::S_MEAN_WAIT;
      end
      srm_pkg::S_MEAN_WAIT: begin
        if (st.div_done) begin
          state_nxt = srm_pkg::S_RATE_GO;
        end
      end
      srm_pkg::S_RATE_GO: begin
        cmd.start_rate = 1'b1;
        state_nxt      = srm_pkg::S_RATE_WAIT;
      end
      srm_pkg::S_RATE_WAIT: begin
        // also the result stage for items that leave the window alone
        if (st.div_done) begin
          cmd.rate_load = 1'b1;
        end else if (!st.div_busy && st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = srm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/srm_dp.sv
module srm_dp #(
  parameter int unsigned WIN_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srm_pkg::cmd_t                       cmd,
  output srm_pkg::stat_t                      st,
  input  logic                                cfg_we,
  input  logic [srm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srm_pkg::CFG_W-1:0]           cfg_data,
  input  logic [srm_pkg::TIME_W-1:0]          in_now_ms,
  input  logic [srm_pkg::PANEL_W-1:0]         in_panels,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [srm_pkg::RATE_W-1:0]          out_rate_per_minute,
  output logic                                out_press_counted,
  output logic [srm_pkg::FILL_W-1:0]          out_window_fill
);

  localparam int unsigned CNT_W = $clog2(WIN_DEPTH + 1);
  localparam int unsigned POS_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int unsigned SUM_W = srm_pkg::IVAL_W + CNT_W;

  logic [srm_pkg::CFG_W-1:0]   double_hit_r;
  logic [srm_pkg::CFG_W-1:0]   timeout_r;
  logic [srm_pkg::TIME_W-1:0]  now_r;
  logic [srm_pkg::PANEL_W-1:0] pads_r;
  logic [srm_pkg::PANEL_W-1:0] prev_r;
  logic [srm_pkg::TIME_W-1:0]  last_r;
  logic                        press_valid_r;
  logic [CNT_W-1:0]            count_r;
  logic [POS_W-1:0]            pos_r;
  logic [SUM_W-1:0]            sum_r;
  logic [srm_pkg::RATE_W-1:0]  rate_r;
  logic                        counted_r;
  logic [srm_pkg::IVAL_W-1:0]  ival_r;
  logic [srm_pkg::IVAL_W-1:0]  rd_r;
  logic                        mean_nz_r;
  logic [srm_pkg::IVAL_W-1:0]  win_mem [WIN_DEPTH];

  logic                        out_valid_r;
  logic [srm_pkg::RATE_W-1:0]  out_rate_r;
  logic                        out_counted_r;
  logic [srm_pkg::FILL_W-1:0]  out_fill_r;

  logic [srm_pkg::TIME_W-1:0]  interval;
  logic                        timeout_hit;
  logic                        gate_open;
  logic                        counted;
  logic                        push_req;
  logic                        win_full;

  logic [SUM_W-1:0]            div_dnd;
  logic [srm_pkg::IVAL_W-1:0]  div_dvs;
  logic [SUM_W-1:0]            div_quo;
  logic                        div_busy;
  logic                        div_done;

  assign interval    = now_r - last_r;
  assign timeout_hit = press_valid_r && (interval > srm_pkg::TIME_W'(timeout_r));
  assign gate_open   = !press_valid_r || (interval > srm_pkg::TIME_W'(double_hit_r));
  assign counted     = gate_open && ((pads_r & ~prev_r) != '0);
  assign push_req    = counted && press_valid_r && !timeout_hit;
  assign win_full    = (count_r == CNT_W'(WIN_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_hit_r <= srm_pkg::DOUBLE_HIT_RST;
      timeout_r    <= srm_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srm_pkg::REG_DOUBLE_HIT: double_hit_r <= cfg_data;
        srm_pkg::REG_TIMEOUT:    timeout_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r  <= in_now_ms;
      pads_r <= in_panels;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r        <= '0;
      last_r        <= '0;
      press_valid_r <= 1'b0;
      count_r       <= '0;
      pos_r         <= '0;
      sum_r         <= '0;
      rate_r        <= '0;
      counted_r     <= 1'b0;
      mean_nz_r     <= 1'b0;
    end else begin
      if (cmd.eval) begin
        if (timeout_hit) begin
          count_r       <= '0;
          pos_r         <= '0;
          sum_r         <= '0;
          rate_r        <= '0;
          press_valid_r <= 1'b0;
          last_r        <= '0;
        end
        if (counted) begin
          press_valid_r <= 1'b1;
          last_r        <= now_r;
        end
        prev_r    <= pads_r;
        counted_r <= counted;
        ival_r    <= interval[srm_pkg::IVAL_W-1:0];
      end
      if (cmd.push) begin
        if (win_full) begin
          sum_r <= sum_r - SUM_W'(rd_r) + SUM_W'(ival_r);
        end else begin
          sum_r   <= sum_r + SUM_W'(ival_r);
          count_r <= count_r + CNT_W'(1);
        end
        if (pos_r == POS_W'(WIN_DEPTH - 1)) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
      if (cmd.start_rate) begin
        mean_nz_r <= (div_quo != '0);
      end
      if (cmd.rate_load && mean_nz_r) begin
        rate_r <= div_quo[srm_pkg::RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_mem[pos_r] <= ival_r;
    end
    if (cmd.read) begin
      rd_r <= win_mem[pos_r];
    end
  end

  // mean = sum / count, then rate = 60000 / mean on the same unit
  assign div_dnd = cmd.start_rate ? SUM_W'(srm_pkg::RATE_NUM) : sum_r;
  assign div_dvs = cmd.start_rate ? div_quo[srm_pkg::IVAL_W-1:0]
                                  : srm_pkg::IVAL_W'(count_r);

  srm_div #(
    .DND_W (SUM_W),
    .DVS_W (srm_pkg::IVAL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_mean || cmd.start_rate),
    .dividend (div_dnd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rate_r    <= rate_r;
      out_counted_r <= counted_r;
      out_fill_r    <= srm_pkg::FILL_W'(count_r);
    end
  end

  assign st.push_req = push_req;
  assign st.div_done = div_done;
  assign st.div_busy = div_busy;
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_rate_per_minute = out_rate_r;
  assign out_press_counted   = out_counted_r;
  assign out_window_fill     = out_fill_r;

endmodule

FILE: bench/step_rate_meter_unit_tb.sv
module step_rate_meter_unit_tb;

  localparam int unsigned WIN = 16;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct {
    logic [srm_pkg::RATE_W-1:0] rate;
    logic                       counted;
    logic [srm_pkg::FILL_W-1:0] fill;
  } meter_reading_t;

  class rate_scoreboard;
    logic [srm_pkg::CFG_W-1:0]   dh_ms;
    logic [srm_pkg::CFG_W-1:0]   to_ms;
    logic [srm_pkg::PANEL_W-1:0] prev_pads;
    logic [srm_pkg::TIME_W-1:0]  last_press;
    bit                          press_seen;
    logic [srm_pkg::IVAL_W-1:0]  intervals [WIN];
    int unsigned                 fill;
    int unsigned                 wr_pos;
    int unsigned                 interval_sum;
    logic [srm_pkg::RATE_W-1:0]  rate;
    meter_reading_t              readings_due [$];
    int unsigned                 err_cnt;

    function new();
      dh_ms = srm_pkg::DOUBLE_HIT_RST;
      to_ms = srm_pkg::TIMEOUT_RST;
      prev_pads = '0;
      err_cnt = 0;
      clear_run();
    endfunction

    function void clear_run();
      fill = 0;
      wr_pos = 0;
      interval_sum = 0;
      rate = '0;
      press_seen = 0;
      last_press = '0;
    endfunction

    function void set_reg(logic [srm_pkg::CFG_IDX_W-1:0] idx,
                          logic [srm_pkg::CFG_W-1:0] val);
      if (idx == srm_pkg::REG_DOUBLE_HIT) begin
        dh_ms = val;
      end else if (idx == srm_pkg::REG_TIMEOUT) begin
        to_ms = val;
      end
    endfunction

    function void push_interval(logic [srm_pkg::IVAL_W-1:0] val);
      if (fill >= WIN) begin
        interval_sum -= intervals[wr_pos];
      end else begin
        fill++;
      end
      intervals[wr_pos] = val;
      interval_sum += val;
      wr_pos = (wr_pos + 1) % WIN;
    endfunction

    function void note_sample(logic [srm_pkg::TIME_W-1:0] now,
                              logic [srm_pkg::PANEL_W-1:0] pads);
      logic [srm_pkg::PANEL_W-1:0] rising;
      logic [srm_pkg::TIME_W-1:0]  gap;
      bit                          gate_ok;
      int unsigned                 mean;
      meter_reading_t              r;
      rising = pads & ~prev_pads;
      gate_ok = 1;
      gap = '0;
      r.counted = 0;
      if (press_seen) begin
        gap = now - last_press;
        if (gap > to_ms) clear_run();
        gate_ok = gap > dh_ms;
      end
      if (gate_ok && rising != '0) begin
        r.counted = 1;
        if (press_seen) begin
          push_interval(gap[srm_pkg::IVAL_W-1:0]);
          mean = interval_sum / fill;
          if (mean != 0) rate = srm_pkg::RATE_W'(srm_pkg::RATE_NUM / mean);
        end
        press_seen = 1;
        last_press = now;
      end
      prev_pads = pads;
      r.rate = rate;
      r.fill = srm_pkg::FILL_W'(fill);
      readings_due.push_back(r);
    endfunction

    function int unsigned pending();
      return readings_due.size();
    endfunction

    task report(string msg);
      err_cnt++;
      if (err_cnt <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [srm_pkg::RATE_W-1:0] rate_got, logic counted_got,
                      logic [srm_pkg::FILL_W-1:0] fill_got);
      meter_reading_t r;
      if (readings_due.size() == 0) begin
        report("result transfer with no sample pending");
        return;
      end
      r = readings_due.pop_front();
      if (rate_got !== r.rate)
        report($sformatf("rate_per_minute got %0d exp %0d", rate_got, r.rate));
      if (counted_got !== r.counted)
        report($sformatf("press_counted got %0d exp %0d", counted_got, r.counted));
      if (fill_got !== r.fill)
        report($sformatf("window_fill got %0d exp %0d", fill_got, r.fill));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [srm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [srm_pkg::CFG_W-1:0] cfg_data;

  srm_in_if  in_ch ();
  srm_out_if out_ch ();

  step_rate_meter_unit #(.WIN_DEPTH(WIN)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rate_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  logic [srm_pkg::TIME_W-1:0] tcur;
  logic [srm_pkg::PANEL_W-1:0] held;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.rate_per_minute, out_ch.press_counted, out_ch.window_fill);
  end

  // receiver: ready follows a randomly drawn duty pattern, or stays high when always_on is drawn
  initial begin
    int unsigned cnt, period, duty;
    bit always_on;
    out_ch.ready = 1'b0;
    cnt = 0;
    period = 1;
    duty = 1;
    always_on = 1;
    forever begin
      @(negedge clk);
      if (cnt % 50 == 0) begin
        always_on = ($urandom_range(0, 2) == 0);
        period = $urandom_range(2, 8);
        duty = $urandom_range(1, period - 1);
      end
      out_ch.ready <= always_on || ((cnt % period) < duty);
      cnt++;
    end
  end

  task send_sample(logic [srm_pkg::TIME_W-1:0] now, logic [srm_pkg::PANEL_W-1:0] pads);
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.now_ms <= now;
    in_ch.panels <= pads;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_sample(now, pads);
  endtask

  task idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  task drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_reg(logic [srm_pkg::CFG_IDX_W-1:0] idx, logic [srm_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task set_config(logic [srm_pkg::CFG_W-1:0] dh, logic [srm_pkg::CFG_W-1:0] to);
    drain();
    repeat (4) @(posedge clk);
    write_reg(srm_pkg::REG_DOUBLE_HIT, dh);
    write_reg(srm_pkg::REG_TIMEOUT, to);
  endtask

  function logic [srm_pkg::TIME_W-1:0] pick_gap();
    logic [srm_pkg::TIME_W-1:0] dh, to;
    int unsigned r;
    dh = srm_pkg::TIME_W'(sb.dh_ms);
    to = srm_pkg::TIME_W'(sb.to_ms);
    r = $urandom_range(0, 19);
    if (r < 2) return $urandom_range(0, dh);
    if (r < 4) return dh + 1;
    if (r < 15) return (to > dh) ? $urandom_range(dh + 1, to) : dh + 1;
    if (r == 15) return to;
    if (r == 16) return to + 1;
    if (r == 17) return to + $urandom_range(1, 5000);
    if (r == 18) return $urandom;
    return '0;
  endfunction

  task emit_random();
    logic [srm_pkg::PANEL_W-1:0] pads;
    if ($urandom_range(0, 9) < 8) begin
      if (held == '0) begin
        tcur += pick_gap();
        pads = srm_pkg::PANEL_W'(1 << $urandom_range(0, srm_pkg::PANEL_W - 1));
        if ($urandom_range(0, 1) == 0) pads |= srm_pkg::PANEL_W'($urandom);
      end else begin
        pads = ($urandom_range(0, 2) == 0) ? (held & srm_pkg::PANEL_W'($urandom)) : '0;
        if ($urandom_range(0, 3) == 0) tcur += $urandom_range(0, 20);
      end
    end else begin
      pads = srm_pkg::PANEL_W'($urandom);
      tcur += ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40);
    end
    held = pads;
    send_sample(tcur, pads);
  endtask

  task run_random(int unsigned n, bit pause_mid);
    int unsigned sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sent < n) begin
        emit_random();
        sent++;
        burst--;
        if (pause_mid && sent == n / 2) drain();
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [srm_pkg::CFG_W-1:0] dh, to;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = srm_pkg::REG_DOUBLE_HIT;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.now_ms = '0;
    in_ch.panels = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: first press at time zero, double hit, timeout, wrap
    send_sample(32'd0, 9'h001);
    send_sample(32'd10, 9'h000);
    send_sample(32'd20, 9'h002);
    send_sample(32'd30, 9'h000);
    send_sample(32'd31, 9'h004);
    send_sample(32'd40, 9'h1FF);
    send_sample(32'd2032, 9'h000);
    send_sample(32'd4000, 9'h100);
    send_sample(32'd4000, 9'h000);
    send_sample(32'd6001, 9'h001);
    send_sample(32'hFFFF_FFF0, 9'h080);
    send_sample(32'hFFFF_FFF8, 9'h000);
    send_sample(32'h0000_0010, 9'h010);
    send_sample(32'h0000_0010, 9'h000);

    // shortest interval gives the top rate
    set_config(16'd0, 16'd1);
    send_sample(32'd100, 9'h001);
    send_sample(32'd100, 9'h000);
    send_sample(32'd101, 9'h002);
    send_sample(32'd101, 9'h000);

    // longest interval that enters the window
    set_config(16'd65534, 16'd65535);
    send_sample(32'd200000, 9'h001);
    send_sample(32'd200000, 9'h000);
    send_sample(32'd265535, 9'h008);
    send_sample(32'd265535, 9'h000);
    send_sample(32'd331071, 9'h020);

    // zero timeout clears on any nonzero interval
    set_config(16'd0, 16'd0);
    send_sample(32'd300000, 9'h040);
    send_sample(32'd300000, 9'h000);
    send_sample(32'd300000, 9'h001);
    send_sample(32'd300000, 9'h000);
    send_sample(32'd300001, 9'h001);

    tcur = 32'd400000;
    held = 9'h001;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin dh = srm_pkg::DOUBLE_HIT_RST; to = srm_pkg::TIMEOUT_RST; end
        1: begin dh = 16'd0;     to = 16'd1;     end
        2: begin dh = 16'd65534; to = 16'd65535; end
        3: begin dh = 16'd0;     to = 16'd65535; end
        4: begin dh = 16'd65535; to = 16'd1;     end
        default: begin
          dh = srm_pkg::CFG_W'($urandom_range(0, 100));
          to = srm_pkg::CFG_W'($urandom_range(dh + 1, 3000));
        end
      endcase
      set_config(dh, to);
      run_random((p == 4) ? 60 : 145, p == 0);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.err_cnt == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
